// File: design/brt_pkg.sv
package brt_pkg;

    localparam int VERTS     = 36;
    localparam int W_IDX     = 6;
    localparam logic [W_IDX-1:0] LAST_IDX = W_IDX'(VERTS - 1);

    localparam int W_SIZE    = 31;
    localparam int W_CTR     = 32;
    localparam int W_TRIG    = 16;
    localparam int W_HPROD   = 62;
    // widest rotated coordinate (after the Z rotation)
    localparam int W_C       = 37;
    localparam int W_PROD    = W_C + W_TRIG;
    localparam int W_SUM     = W_PROD + 1;
    localparam int W_FIN     = W_C + 1;

    // sqrt(1/12) in unsigned Q0.32
    localparam logic [W_SIZE-1:0] SCALE_Q32 = W_SIZE'(1239850262);

    typedef struct packed {
        logic [W_SIZE-1:0]        sx;
        logic [W_SIZE-1:0]        sy;
        logic [W_SIZE-1:0]        sz;
        logic signed [W_TRIG-1:0] xc;
        logic signed [W_TRIG-1:0] xs;
        logic signed [W_TRIG-1:0] yc;
        logic signed [W_TRIG-1:0] ys;
        logic signed [W_TRIG-1:0] zc;
        logic signed [W_TRIG-1:0] zs;
        logic signed [W_CTR-1:0]  cx;
        logic signed [W_CTR-1:0]  cy;
        logic signed [W_CTR-1:0]  cz;
    } t_box;

    typedef struct packed {
        logic             valid;
        logic [W_IDX-1:0] idx;
        t_box             box;
    } t_req;

    typedef struct packed {
        logic [W_IDX-1:0]         idx;
        logic signed [W_C-1:0]    x;
        logic signed [W_C-1:0]    y;
        logic signed [W_C-1:0]    z;
        logic signed [W_TRIG-1:0] xc;
        logic signed [W_TRIG-1:0] xs;
        logic signed [W_TRIG-1:0] yc;
        logic signed [W_TRIG-1:0] ys;
        logic signed [W_TRIG-1:0] zc;
        logic signed [W_TRIG-1:0] zs;
        logic signed [W_CTR-1:0]  cx;
        logic signed [W_CTR-1:0]  cy;
        logic signed [W_CTR-1:0]  cz;
    } t_vtx;

    // corner signs per vertex: bit0 = +x, bit1 = +y, bit2 = +z
    function automatic logic [2:0] brt_corner(input logic [W_IDX-1:0] idx);
        logic [2:0] m;
        case (idx)
            6'd0:  m = 3'd0;  6'd1:  m = 3'd1;  6'd2:  m = 3'd2;  6'd3:  m = 3'd1;
            6'd4:  m = 3'd2;  6'd5:  m = 3'd3;  6'd6:  m = 3'd2;  6'd7:  m = 3'd3;
            6'd8:  m = 3'd6;  6'd9:  m = 3'd6;  6'd10: m = 3'd3;  6'd11: m = 3'd7;
            6'd12: m = 3'd1;  6'd13: m = 3'd3;  6'd14: m = 3'd7;  6'd15: m = 3'd7;
            6'd16: m = 3'd1;  6'd17: m = 3'd5;  6'd18: m = 3'd4;  6'd19: m = 3'd5;
            6'd20: m = 3'd6;  6'd21: m = 3'd5;  6'd22: m = 3'd6;  6'd23: m = 3'd7;
            6'd24: m = 3'd0;  6'd25: m = 3'd1;  6'd26: m = 3'd4;  6'd27: m = 3'd4;
            6'd28: m = 3'd1;  6'd29: m = 3'd5;  6'd30: m = 3'd0;  6'd31: m = 3'd2;
            6'd32: m = 3'd6;  6'd33: m = 3'd6;  6'd34: m = 3'd0;  6'd35: m = 3'd4;
            default: m = 3'd0;
        endcase
        return m;
    endfunction

    // Q.30 sum to Q16.16, ties toward plus infinity
    function automatic logic signed [W_C-1:0] brt_round(input logic signed [W_SUM-1:0] s);
        logic signed [W_SUM-1:0] t;
        t = s + W_SUM'(8192);
        return t[W_C+13:14];
    endfunction

    function automatic logic [W_CTR-1:0] brt_sat(input logic signed [W_FIN-1:0] v);
        logic [W_CTR-1:0] r;
        if (v > W_FIN'(32'sh7FFF_FFFF)) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -W_FIN'(64'sh8000_0000)) begin
            r = 32'h8000_0000;
        end else begin
            r = v[W_CTR-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/brt_seq.sv
module brt_seq
    import brt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [W_CTR-1:0]  i_center_x,
    input  logic signed [W_CTR-1:0]  i_center_y,
    input  logic signed [W_CTR-1:0]  i_center_z,
    input  logic [W_SIZE-1:0]        i_size_x,
    input  logic [W_SIZE-1:0]        i_size_y,
    input  logic [W_SIZE-1:0]        i_size_z,
    input  logic signed [W_TRIG-1:0] i_rot_x_cos,
    input  logic signed [W_TRIG-1:0] i_rot_x_sin,
    input  logic signed [W_TRIG-1:0] i_rot_y_cos,
    input  logic signed [W_TRIG-1:0] i_rot_y_sin,
    input  logic signed [W_TRIG-1:0] i_rot_z_cos,
    input  logic signed [W_TRIG-1:0] i_rot_z_sin,
    output t_req                     o_req
);

    logic             r_busy;
    logic [W_IDX-1:0] r_idx;
    t_box             r_box;
    logic             issue_last;
    logic             load;

    always_comb begin
        issue_last = r_busy && i_adv && (r_idx == LAST_IDX);
        o_stall    = r_busy && !issue_last;
        load       = i_valid && !o_stall;
        o_req.valid = r_busy;
        o_req.idx   = r_idx;
        o_req.box   = r_box;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_adv) begin
            if (r_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_box.sx <= i_size_x;
            r_box.sy <= i_size_y;
            r_box.sz <= i_size_z;
            r_box.xc <= i_rot_x_cos;
            r_box.xs <= i_rot_x_sin;
            r_box.yc <= i_rot_y_cos;
            r_box.ys <= i_rot_y_sin;
            r_box.zc <= i_rot_z_cos;
            r_box.zs <= i_rot_z_sin;
            r_box.cx <= i_center_x;
            r_box.cy <= i_center_y;
            r_box.cz <= i_center_z;
        end
    end

    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_busy && (r_idx == '0))
        else $error("box load did not restart vertex count");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && i_adv && (r_idx != LAST_IDX) |=> r_busy && (r_idx == $past(r_idx) + 1'b1))
        else $error("vertex index skipped or stuck");

    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_adv |=> r_busy && $stable(r_idx))
        else $error("vertex index moved while pipeline held");

endmodule

// File: design/brt_rot.sv
module brt_rot
    import brt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    input  t_vtx                     i_v,
    input  logic signed [W_C-1:0]    i_a,
    input  logic signed [W_C-1:0]    i_b,
    input  logic signed [W_TRIG-1:0] i_c,
    input  logic signed [W_TRIG-1:0] i_s,
    output logic                     o_valid,
    output t_vtx                     o_v,
    output logic signed [W_C-1:0]    o_p,
    output logic signed [W_C-1:0]    o_q
);

    // p = a*c + b*s, q = b*c - a*s
    logic                      r_m_valid;
    t_vtx                      r_m_v;
    logic signed [W_PROD-1:0]  r_ac;
    logic signed [W_PROD-1:0]  r_bs;
    logic signed [W_PROD-1:0]  r_as;
    logic signed [W_PROD-1:0]  r_bc;
    logic                      r_valid;
    t_vtx                      r_v;
    logic signed [W_C-1:0]     r_p;
    logic signed [W_C-1:0]     r_q;
    logic signed [W_SUM-1:0]   n_psum;
    logic signed [W_SUM-1:0]   n_qsum;

    always_comb begin
        n_psum = W_SUM'(r_ac) + W_SUM'(r_bs);
        n_qsum = W_SUM'(r_bc) - W_SUM'(r_as);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_adv) begin
            r_m_valid <= i_valid;
            r_valid   <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m_v <= i_v;
            r_ac  <= W_PROD'(i_a) * W_PROD'(i_c);
            r_bs  <= W_PROD'(i_b) * W_PROD'(i_s);
            r_as  <= W_PROD'(i_a) * W_PROD'(i_s);
            r_bc  <= W_PROD'(i_b) * W_PROD'(i_c);
            r_v   <= r_m_v;
            r_p   <= brt_round(n_psum);
            r_q   <= brt_round(n_qsum);
        end
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_p     = r_p;
    assign o_q     = r_q;

endmodule

// File: design/box_mesh_rotate_translate.sv
// A box's vertices pass the sequencer, stages 1 and 2, the X, Y and Z rotations and the output register.
// Throughput: one vertex per cycle while the output does not stall; the vertex sequencer issues one
// vertex a cycle unless held and takes the next box in the cycle its last vertex issues.
// The pipeline is nine register stages deep and holds all stages while the output stalls.
// Reset is synchronous and active low; it clears the sequencer and every stage valid.
module box_mesh_rotate_translate
    import brt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [W_CTR-1:0]  i_center_x,
    input  logic signed [W_CTR-1:0]  i_center_y,
    input  logic signed [W_CTR-1:0]  i_center_z,
    input  logic [W_SIZE-1:0]        i_size_x,
    input  logic [W_SIZE-1:0]        i_size_y,
    input  logic [W_SIZE-1:0]        i_size_z,
    input  logic signed [W_TRIG-1:0] i_rot_x_cos,
    input  logic signed [W_TRIG-1:0] i_rot_x_sin,
    input  logic signed [W_TRIG-1:0] i_rot_y_cos,
    input  logic signed [W_TRIG-1:0] i_rot_y_sin,
    input  logic signed [W_TRIG-1:0] i_rot_z_cos,
    input  logic signed [W_TRIG-1:0] i_rot_z_sin,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [W_CTR-1:0]  o_vertex_x,
    output logic signed [W_CTR-1:0]  o_vertex_y,
    output logic signed [W_CTR-1:0]  o_vertex_z,
    output logic [W_IDX-1:0]         o_vertex_index,
    output logic                     o_last_vertex
);

    logic                   adv;
    t_req                   req;

    logic                   r_s1_valid;
    logic [W_IDX-1:0]       r_s1_idx;
    t_box                   r_s1_box;
    logic [W_HPROD-1:0]     r_s1_px;
    logic [W_HPROD-1:0]     r_s1_py;
    logic [W_HPROD-1:0]     r_s1_pz;

    logic                   r_s2_valid;
    t_vtx                   r_s2;
    t_vtx                   n_s2;
    logic [W_HPROD-1:0]     hx_rnd;
    logic [W_HPROD-1:0]     hy_rnd;
    logic [W_HPROD-1:0]     hz_rnd;
    logic signed [W_C-1:0]  hx;
    logic signed [W_C-1:0]  hy;
    logic signed [W_C-1:0]  hz;
    logic [2:0]             corner;

    logic                   rx_valid;
    t_vtx                   rx_v;
    logic signed [W_C-1:0]  rx_p;
    logic signed [W_C-1:0]  rx_q;
    t_vtx                   after_x;

    logic                   ry_valid;
    t_vtx                   ry_v;
    logic signed [W_C-1:0]  ry_p;
    logic signed [W_C-1:0]  ry_q;
    t_vtx                   after_y;

    logic                   rz_valid;
    t_vtx                   rz_v;
    logic signed [W_C-1:0]  rz_p;
    logic signed [W_C-1:0]  rz_q;

    logic                   r_out_valid;
    logic [W_CTR-1:0]       r_vx;
    logic [W_CTR-1:0]       r_vy;
    logic [W_CTR-1:0]       r_vz;
    logic [W_IDX-1:0]       r_vidx;
    logic                   r_vlast;

    // advance every stage together unless the output word is held
    assign adv = !r_out_valid || !i_stall;

    brt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .i_size_x    (i_size_x),
        .i_size_y    (i_size_y),
        .i_size_z    (i_size_z),
        .i_rot_x_cos (i_rot_x_cos),
        .i_rot_x_sin (i_rot_x_sin),
        .i_rot_y_cos (i_rot_y_cos),
        .i_rot_y_sin (i_rot_y_sin),
        .i_rot_z_cos (i_rot_z_cos),
        .i_rot_z_sin (i_rot_z_sin),
        .o_req       (req)
    );

    // stage 1: scale extents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_idx <= req.idx;
            r_s1_box <= req.box;
            r_s1_px  <= W_HPROD'(req.box.sx) * W_HPROD'(SCALE_Q32);
            r_s1_py  <= W_HPROD'(req.box.sy) * W_HPROD'(SCALE_Q32);
            r_s1_pz  <= W_HPROD'(req.box.sz) * W_HPROD'(SCALE_Q32);
        end
    end

    // stage 2: round half extents, apply corner signs
    always_comb begin
        hx_rnd = r_s1_px + W_HPROD'(64'h8000_0000);
        hy_rnd = r_s1_py + W_HPROD'(64'h8000_0000);
        hz_rnd = r_s1_pz + W_HPROD'(64'h8000_0000);
        hx     = W_C'(hx_rnd[W_HPROD-1:32]);
        hy     = W_C'(hy_rnd[W_HPROD-1:32]);
        hz     = W_C'(hz_rnd[W_HPROD-1:32]);
        corner = brt_corner(r_s1_idx);
        n_s2.idx = r_s1_idx;
        n_s2.x   = corner[0] ? hx : -hx;
        n_s2.y   = corner[1] ? hy : -hy;
        n_s2.z   = corner[2] ? hz : -hz;
        n_s2.xc  = r_s1_box.xc;
        n_s2.xs  = r_s1_box.xs;
        n_s2.yc  = r_s1_box.yc;
        n_s2.ys  = r_s1_box.ys;
        n_s2.zc  = r_s1_box.zc;
        n_s2.zs  = r_s1_box.zs;
        n_s2.cx  = r_s1_box.cx;
        n_s2.cy  = r_s1_box.cy;
        n_s2.cz  = r_s1_box.cz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2 <= n_s2;
        end
    end

    // rotate about X: y, z
    brt_rot u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_s2_valid),
        .i_v     (r_s2),
        .i_a     (r_s2.y),
        .i_b     (r_s2.z),
        .i_c     (r_s2.xc),
        .i_s     (r_s2.xs),
        .o_valid (rx_valid),
        .o_v     (rx_v),
        .o_p     (rx_p),
        .o_q     (rx_q)
    );

    always_comb begin
        after_x   = rx_v;
        after_x.y = rx_p;
        after_x.z = rx_q;
    end

    // rotate about Y: x, z
    brt_rot u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (rx_valid),
        .i_v     (after_x),
        .i_a     (after_x.x),
        .i_b     (after_x.z),
        .i_c     (after_x.yc),
        .i_s     (after_x.ys),
        .o_valid (ry_valid),
        .o_v     (ry_v),
        .o_p     (ry_p),
        .o_q     (ry_q)
    );

    always_comb begin
        after_y   = ry_v;
        after_y.x = ry_p;
        after_y.z = ry_q;
    end

    // rotate about Z: x, y
    brt_rot u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (ry_valid),
        .i_v     (after_y),
        .i_a     (after_y.x),
        .i_b     (after_y.y),
        .i_c     (after_y.zc),
        .i_s     (after_y.zs),
        .o_valid (rz_valid),
        .o_v     (rz_v),
        .o_p     (rz_p),
        .o_q     (rz_q)
    );

    // translate, saturate, output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= rz_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_vx    <= brt_sat(W_FIN'(rz_p) + W_FIN'(rz_v.cx));
            r_vy    <= brt_sat(W_FIN'(rz_q) + W_FIN'(rz_v.cy));
            r_vz    <= brt_sat(W_FIN'(rz_v.z) + W_FIN'(rz_v.cz));
            r_vidx  <= rz_v.idx;
            r_vlast <= (rz_v.idx == LAST_IDX);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_vertex_x     = r_vx;
    assign o_vertex_y     = r_vy;
    assign o_vertex_z     = r_vz;
    assign o_vertex_index = r_vidx;
    assign o_last_vertex  = r_vlast;

    a_vertex_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_vertex_index != LAST_IDX)
        |=> o_valid && (o_vertex_index == $past(o_vertex_index) + 1'b1))
        else $error("vertices of a box not delivered back to back in order");

endmodule

// File: dv/box_mesh_rotate_translate_tb.sv
`timescale 1ns / 100ps

module box_mesh_rotate_translate_tb;
    import brt_pkg::*;

    localparam logic signed [W_TRIG-1:0] Q14_ONE   = 16'sd16384;
    localparam logic signed [W_TRIG-1:0] Q14_HALF  = 16'sd8192;
    localparam logic signed [W_TRIG-1:0] TRIG_MIN  = 16'sh8000;
    localparam logic signed [W_TRIG-1:0] TRIG_MAX  = 16'sh7FFF;
    localparam logic [W_SIZE-1:0]        SIZE_MAX  = 31'h7FFF_FFFF;
    localparam logic signed [W_CTR-1:0]  CTR_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [W_CTR-1:0]  CTR_MIN   = 32'sh8000_0000;
    localparam int                       N_RANDOM  = 410;
    // corner sign codes, vertex 0 in the low digit: bit0 = +x, bit1 = +y, bit2 = +z
    localparam logic [107:0] CORNER_SIGNS =
        108'o406620514410_765654517731_736632321210;

    typedef struct {
        logic signed [W_CTR-1:0]  cx, cy, cz;
        logic [W_SIZE-1:0]        sx, sy, sz;
        logic signed [W_TRIG-1:0] xc, xs, yc, ys, zc, zs;
        bit                       drain;
    } box_t;

    typedef struct {
        logic signed [W_CTR-1:0] x, y, z;
        logic [W_IDX-1:0]        idx;
        logic                    last;
    } vertex_t;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [W_CTR-1:0]  i_center_x = '0;
    logic signed [W_CTR-1:0]  i_center_y = '0;
    logic signed [W_CTR-1:0]  i_center_z = '0;
    logic [W_SIZE-1:0]        i_size_x = '0;
    logic [W_SIZE-1:0]        i_size_y = '0;
    logic [W_SIZE-1:0]        i_size_z = '0;
    logic signed [W_TRIG-1:0] i_rot_x_cos = '0;
    logic signed [W_TRIG-1:0] i_rot_x_sin = '0;
    logic signed [W_TRIG-1:0] i_rot_y_cos = '0;
    logic signed [W_TRIG-1:0] i_rot_y_sin = '0;
    logic signed [W_TRIG-1:0] i_rot_z_cos = '0;
    logic signed [W_TRIG-1:0] i_rot_z_sin = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [W_CTR-1:0]  o_vertex_x;
    logic signed [W_CTR-1:0]  o_vertex_y;
    logic signed [W_CTR-1:0]  o_vertex_z;
    logic [W_IDX-1:0]         o_vertex_index;
    logic                     o_last_vertex;

    box_t    pending_boxes[$];
    vertex_t expected_vertices[$];
    box_t    box_in_flight;
    box_t    next_box;
    int      mismatch_count = 0;
    int      send_gap = 0;
    int      stall_left = 0;
    int      stall_draw;
    bit      send_quiet = 1'b0;
    bit      recv_quiet = 1'b0;

    box_mesh_rotate_translate uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_center_z     (i_center_z),
        .i_size_x       (i_size_x),
        .i_size_y       (i_size_y),
        .i_size_z       (i_size_z),
        .i_rot_x_cos    (i_rot_x_cos),
        .i_rot_x_sin    (i_rot_x_sin),
        .i_rot_y_cos    (i_rot_y_cos),
        .i_rot_y_sin    (i_rot_y_sin),
        .i_rot_z_cos    (i_rot_z_cos),
        .i_rot_z_sin    (i_rot_z_sin),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_vertex_x     (o_vertex_x),
        .o_vertex_y     (o_vertex_y),
        .o_vertex_z     (o_vertex_z),
        .o_vertex_index (o_vertex_index),
        .o_last_vertex  (o_last_vertex)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint half_extent(input logic [W_SIZE-1:0] size);
        logic [63:0] p;
        p = {33'd0, size} * 64'd1239850262 + 64'h8000_0000;
        return longint'(p >> 32);
    endfunction

    // exact two-term dot product, rounded Q.30 -> Q16.16 with ties toward +inf
    function automatic longint rotate_term(input longint a, input longint c,
                                           input longint b, input longint s);
        longint t;
        t = a * c + b * s + 64'sd8192;
        return t >>> 14;
    endfunction

    function automatic logic signed [W_CTR-1:0] clamp32(input longint v);
        logic signed [W_CTR-1:0] r;
        if (v > 64'sd2147483647) begin
            r = CTR_MAX;
        end else if (v < -64'sd2147483648) begin
            r = CTR_MIN;
        end else begin
            r = v[W_CTR-1:0];
        end
        return r;
    endfunction

    task automatic predict_box_vertices(input box_t b);
        longint  hx, hy, hz, px, py, pz, t0, t1;
        longint  xc, xs, yc, ys, zc, zs;
        logic [2:0] m;
        vertex_t v;
        hx = half_extent(b.sx);
        hy = half_extent(b.sy);
        hz = half_extent(b.sz);
        xc = longint'(b.xc);
        xs = longint'(b.xs);
        yc = longint'(b.yc);
        ys = longint'(b.ys);
        zc = longint'(b.zc);
        zs = longint'(b.zs);
        for (int k = 0; k < VERTS; k++) begin
            m  = CORNER_SIGNS[k*3 +: 3];
            px = m[0] ? hx : -hx;
            py = m[1] ? hy : -hy;
            pz = m[2] ? hz : -hz;
            t0 = rotate_term(py, xc, pz, xs);
            t1 = rotate_term(py, -xs, pz, xc);
            py = t0;
            pz = t1;
            t0 = rotate_term(px, yc, pz, ys);
            t1 = rotate_term(px, -ys, pz, yc);
            px = t0;
            pz = t1;
            t0 = rotate_term(px, zc, py, zs);
            t1 = rotate_term(px, -zs, py, zc);
            px = t0;
            py = t1;
            v.x    = clamp32(px + longint'(b.cx));
            v.y    = clamp32(py + longint'(b.cy));
            v.z    = clamp32(pz + longint'(b.cz));
            v.idx  = W_IDX'(k);
            v.last = (k == VERTS - 1);
            expected_vertices.push_back(v);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0.1f ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic box_t make_box(
        input logic signed [W_CTR-1:0] cx, input logic signed [W_CTR-1:0] cy,
        input logic signed [W_CTR-1:0] cz,
        input logic [W_SIZE-1:0] sx, input logic [W_SIZE-1:0] sy,
        input logic [W_SIZE-1:0] sz,
        input logic signed [W_TRIG-1:0] xc, input logic signed [W_TRIG-1:0] xs,
        input logic signed [W_TRIG-1:0] yc, input logic signed [W_TRIG-1:0] ys,
        input logic signed [W_TRIG-1:0] zc, input logic signed [W_TRIG-1:0] zs);
        box_t b;
        b.cx = cx; b.cy = cy; b.cz = cz;
        b.sx = sx; b.sy = sy; b.sz = sz;
        b.xc = xc; b.xs = xs; b.yc = yc; b.ys = ys; b.zc = zc; b.zs = zs;
        b.drain = 1'b0;
        return b;
    endfunction

    function automatic logic signed [W_TRIG-1:0] random_trig();
        logic signed [W_TRIG-1:0] r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: r = W_TRIG'(int'($urandom_range(0, 32768)) - 16384);
            6: begin
                case ($urandom_range(0, 4))
                    0: r = Q14_ONE;
                    1: r = -Q14_ONE;
                    2: r = '0;
                    3: r = TRIG_MIN;
                    default: r = TRIG_MAX;
                endcase
            end
            default: r = W_TRIG'($urandom);
        endcase
        return r;
    endfunction

    function automatic logic [W_SIZE-1:0] random_size();
        logic [W_SIZE-1:0] r;
        case ($urandom_range(0, 5))
            0: r = W_SIZE'($urandom);
            1, 2: r = W_SIZE'($urandom >> $urandom_range(8, 31));
            3: r = W_SIZE'($urandom_range(0, 64));
            4: r = ($urandom_range(0, 1) != 0) ? SIZE_MAX : W_SIZE'($urandom_range(0, 1));
            default: r = W_SIZE'($urandom >> $urandom_range(0, 31));
        endcase
        return r;
    endfunction

    function automatic logic signed [W_CTR-1:0] random_center();
        logic signed [W_CTR-1:0] r;
        case ($urandom_range(0, 5))
            0: r = W_CTR'($urandom);
            1, 2, 3: begin
                r = W_CTR'($urandom >> $urandom_range(1, 31));
                if ($urandom_range(0, 1) != 0) r = -r;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: r = CTR_MAX;
                    1: r = CTR_MIN;
                    2: r = '0;
                    default: r = -32'sd1;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic box_t random_box();
        box_t b;
        b = make_box(random_center(), random_center(), random_center(),
                     random_size(), random_size(), random_size(),
                     random_trig(), random_trig(), random_trig(),
                     random_trig(), random_trig(), random_trig());
        b.drain = ($urandom_range(0, 39) == 0);
        return b;
    endfunction

    // driver: one box word per handshake, random gap after each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                predict_box_vertices(box_in_flight);
            end
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (pending_boxes.size() != 0 &&
                         !(pending_boxes[0].drain && expected_vertices.size() != 0)) begin
                next_box      = pending_boxes.pop_front();
                box_in_flight <= next_box;
                i_center_x    <= next_box.cx;
                i_center_y    <= next_box.cy;
                i_center_z    <= next_box.cz;
                i_size_x      <= next_box.sx;
                i_size_y      <= next_box.sy;
                i_size_z      <= next_box.sz;
                i_rot_x_cos   <= next_box.xc;
                i_rot_x_sin   <= next_box.xs;
                i_rot_y_cos   <= next_box.yc;
                i_rot_y_sin   <= next_box.ys;
                i_rot_z_cos   <= next_box.zc;
                i_rot_z_sin   <= next_box.zs;
                i_valid       <= 1'b1;
                if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
                send_gap <= send_quiet ? 0 : $urandom_range(0, 10);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: check each accepted vertex word, then draw a stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && !i_stall) begin
            if (expected_vertices.size() == 0) begin
                report_mismatch($sformatf("unexpected vertex, index %0d", o_vertex_index));
            end else begin
                vertex_t want;
                want = expected_vertices.pop_front();
                if (o_vertex_x !== want.x)
                    report_mismatch($sformatf("vertex %0d x: got %0d, want %0d",
                                              want.idx, o_vertex_x, want.x));
                if (o_vertex_y !== want.y)
                    report_mismatch($sformatf("vertex %0d y: got %0d, want %0d",
                                              want.idx, o_vertex_y, want.y));
                if (o_vertex_z !== want.z)
                    report_mismatch($sformatf("vertex %0d z: got %0d, want %0d",
                                              want.idx, o_vertex_z, want.z));
                if (o_vertex_index !== want.idx)
                    report_mismatch($sformatf("vertex index: got %0d, want %0d",
                                              o_vertex_index, want.idx));
                if (o_last_vertex !== want.last)
                    report_mismatch($sformatf("vertex %0d last flag: got %b, want %b",
                                              want.idx, o_last_vertex, want.last));
            end
            if ($urandom_range(0, 63) == 0) recv_quiet = !recv_quiet;
            stall_draw = recv_quiet ? 0 : $urandom_range(0, 10);
            i_stall    <= (stall_draw != 0);
            stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
        end else if (i_stall) begin
            if (stall_left == 0) begin
                i_stall <= 1'b0;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    initial begin
        box_t b;

        // all zero, then plain identity rotation
        pending_boxes.push_back(make_box('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_boxes.push_back(make_box('0, '0, '0, 31'h1_0000, 31'h2_0000, 31'h3_0000,
                                         Q14_ONE, '0, Q14_ONE, '0, Q14_ONE, '0));
        // half extent of one LSB times a half cosine: rounding ties both ways
        pending_boxes.push_back(make_box('0, '0, '0, 31'd4, 31'd4, 31'd4,
                                         Q14_HALF, '0, Q14_ONE, '0, Q14_ONE, '0));
        // zero extents: every vertex sits on the center
        pending_boxes.push_back(make_box(CTR_MAX, CTR_MIN, 32'sh1234_5678, '0, '0, '0,
                                         random_trig(), random_trig(), random_trig(),
                                         random_trig(), random_trig(), random_trig()));
        // largest extents, with and without saturating centers
        pending_boxes.push_back(make_box('0, '0, '0, SIZE_MAX, SIZE_MAX, SIZE_MAX,
                                         Q14_ONE, '0, Q14_ONE, '0, Q14_ONE, '0));
        pending_boxes.push_back(make_box(CTR_MAX, CTR_MAX, CTR_MAX, SIZE_MAX, SIZE_MAX,
                                         SIZE_MAX, Q14_ONE, '0, Q14_ONE, '0, Q14_ONE, '0));
        pending_boxes.push_back(make_box(CTR_MIN, CTR_MIN, CTR_MIN, SIZE_MAX, SIZE_MAX,
                                         SIZE_MAX, Q14_ONE, '0, Q14_ONE, '0, Q14_ONE, '0));
        // out-of-range trig scales the box
        pending_boxes.push_back(make_box('0, '0, '0, SIZE_MAX, SIZE_MAX, SIZE_MAX,
                                         TRIG_MIN, TRIG_MIN, TRIG_MIN, TRIG_MIN,
                                         TRIG_MIN, TRIG_MIN));
        pending_boxes.push_back(make_box(-32'sd1, -32'sd1, -32'sd1, SIZE_MAX, SIZE_MAX,
                                         SIZE_MAX, TRIG_MAX, TRIG_MAX, TRIG_MAX, TRIG_MAX,
                                         TRIG_MAX, TRIG_MAX));
        pending_boxes.push_back(make_box(CTR_MAX, CTR_MIN, CTR_MAX, SIZE_MAX, SIZE_MAX,
                                         SIZE_MAX, TRIG_MIN, TRIG_MIN, TRIG_MIN, TRIG_MIN,
                                         TRIG_MIN, TRIG_MIN));
        // quarter turns about each axis, then half turns and negative quarter turns about all three
        pending_boxes.push_back(make_box(32'sh10_0000, '0, '0, 31'h1_0000, 31'h2_0000,
                                         31'h4_0000, '0, Q14_ONE, Q14_ONE, '0, Q14_ONE, '0));
        pending_boxes.push_back(make_box('0, 32'sh10_0000, '0, 31'h1_0000, 31'h2_0000,
                                         31'h4_0000, Q14_ONE, '0, '0, Q14_ONE, Q14_ONE, '0));
        pending_boxes.push_back(make_box('0, '0, -32'sh10_0000, 31'h1_0000, 31'h2_0000,
                                         31'h4_0000, Q14_ONE, '0, Q14_ONE, '0, '0, Q14_ONE));
        pending_boxes.push_back(make_box('0, '0, '0, 31'h1_0000, 31'h2_0000, 31'h4_0000,
                                         -Q14_ONE, '0, -Q14_ONE, '0, -Q14_ONE, '0));
        pending_boxes.push_back(make_box('0, '0, '0, 31'h3_0000, 31'h5_0000, 31'h7_0000,
                                         '0, -Q14_ONE, '0, -Q14_ONE, '0, -Q14_ONE));
        // inconsistent pair; hold this one until the pipeline drains
        b = make_box(32'sh1_8000, -32'sh2_8000, 32'sh3_8000, 31'h5_5555, 31'h2_AAAA,
                     31'h7_0F0F, Q14_ONE, Q14_ONE, Q14_ONE, Q14_ONE, Q14_ONE, Q14_ONE);
        b.drain = 1'b1;
        pending_boxes.push_back(b);

        for (int i = 0; i < N_RANDOM; i++) begin
            pending_boxes.push_back(random_box());
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_boxes.size() != 0 || i_valid || expected_vertices.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout, %0d vertices still expected", expected_vertices.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: box_mesh_rotate_translate.f
design/brt_pkg.sv
design/brt_seq.sv
design/brt_rot.sv
design/box_mesh_rotate_translate.sv
dv/box_mesh_rotate_translate_tb.sv
